/* rtl/core/file_uri_percent_decoder_unit_assert.svh */
// Assertion macros used by the decoder back end, fupd_back.
// Each macro expects i_clk and i_rst_n in the module that uses it.
`ifndef FILE_URI_PERCENT_DECODER_UNIT_ASSERT_SVH
`define FILE_URI_PERCENT_DECODER_UNIT_ASSERT_SVH

// The consequence must hold in the same cycle as the antecedent.
`define FUPD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequence must hold in the cycle after the antecedent.
`define FUPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/fupd_pkg.sv */
`timescale 1ns / 1ps

package fupd_pkg;

    localparam int         PREFIX_LEN = 7;
    localparam logic [7:0] CH_PCT     = 8'h25;
    localparam logic [2:0] TAIL_FULL  = 3'd4;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_end;
    } t_token;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       end_of_string;
        logic       status;
        logic       pdf_suffix;
    } t_result;

    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = "f";
            3'd1:    ch = "i";
            3'd2:    ch = "l";
            3'd3:    ch = "e";
            3'd4:    ch = ":";
            default: ch = "/";
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] pdf_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = ".";
            2'd1:    ch = "p";
            2'd2:    ch = "d";
            default: ch = "f";
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= "A" && c <= "Z") begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        logic [7:0] l;
        l = to_lower(c);
        return (c >= "0" && c <= "9") || (l >= "a" && l <= "f");
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] l;
        logic [7:0] v;
        l = to_lower(c);
        if (c >= "0" && c <= "9") begin
            v = c - "0";
        end else begin
            v = l - "a" + 8'd10;
        end
        return v[3:0];
    endfunction

endpackage

/* rtl/core/fupd_front.sv */
`timescale 1ns / 1ps

module fupd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_in_char,
    input  logic            i_has_char,
    input  logic            i_is_last,
    output logic            o_tok_valid,
    output fupd_pkg::t_token o_tok,
    input  logic            i_tok_ready
);

    logic [2:0] r_prog;
    logic       r_done;
    logic       r_pv;
    logic [2:0] r_idx;
    logic [2:0] r_n;
    logic [7:0] r_c;
    logic       r_ec;
    logic       r_ee;

    logic [2:0] prog_inc;
    logic       match;
    logic       complete;
    logic       mismatch;
    logic       plan_ec;
    logic [2:0] plan_n;
    logic       plan_any;
    logic       in_flush;
    logic       push;
    logic       final_tok;
    logic       accept;

    assign prog_inc = r_prog + 3'd1;
    assign match    = i_has_char && !r_done && (i_in_char == fupd_pkg::prefix_char(r_prog));
    assign complete = match && (prog_inc == 3'(fupd_pkg::PREFIX_LEN));
    assign mismatch = i_has_char && !r_done && !match;
    assign plan_ec  = i_has_char && (r_done || mismatch);

    always_comb begin
        plan_n = 3'd0;
        if (mismatch) begin
            plan_n = r_prog;
        end else if (i_is_last && !r_done && !complete) begin
            plan_n = match ? prog_inc : r_prog;
        end
    end

    assign plan_any = plan_ec || i_is_last || (plan_n != 3'd0);

    assign in_flush      = r_idx < r_n;
    assign o_tok.ch      = in_flush ? fupd_pkg::prefix_char(r_idx) : r_c;
    assign o_tok.is_end  = !in_flush && !r_ec;
    assign o_tok_valid   = r_pv;
    assign push          = r_pv && i_tok_ready;
    assign final_tok     = in_flush ? ((3'(r_idx + 3'd1) == r_n) && !r_ec && !r_ee)
                                    : (r_ec ? !r_ee : 1'b1);
    assign o_ready       = !r_pv || (push && final_tok);
    assign accept        = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog <= 3'd0;
            r_done <= 1'b0;
            r_pv   <= 1'b0;
            r_ec   <= 1'b0;
            r_ee   <= 1'b0;
        end else begin
            if (accept) begin
                r_pv  <= plan_any;
                r_idx <= 3'd0;
                r_n   <= plan_n;
                r_c   <= i_in_char;
                r_ec  <= plan_ec;
                r_ee  <= i_is_last;
                if (i_is_last) begin
                    r_prog <= 3'd0;
                    r_done <= 1'b0;
                end else if (match) begin
                    r_prog <= complete ? 3'd0 : prog_inc;
                    r_done <= complete;
                end else if (mismatch) begin
                    r_prog <= 3'd0;
                    r_done <= 1'b1;
                end
            end else if (push) begin
                if (in_flush) begin
                    r_idx <= r_idx + 3'd1;
                end else if (r_ec) begin
                    r_ec <= 1'b0;
                end else begin
                    r_ee <= 1'b0;
                end
                if (final_tok) begin
                    r_pv <= 1'b0;
                end
            end
        end
    end

endmodule

/* rtl/core/fupd_queue.sv */
`timescale 1ns / 1ps

module fupd_queue #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  fupd_pkg::t_token i_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output fupd_pkg::t_token o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    fupd_pkg::t_token r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;

    logic push;
    logic pop;

    assign o_push_ready = r_cnt != CW'(DEPTH);
    assign o_pop_valid  = r_cnt != '0;
    assign o_data       = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

/* rtl/core/fupd_back.sv */
`timescale 1ns / 1ps

`include "file_uri_percent_decoder_unit_assert.svh"

module fupd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_tok_valid,
    output logic              o_tok_ready,
    input  fupd_pkg::t_token  i_tok,
    output logic              o_res_valid,
    output fupd_pkg::t_result o_res,
    input  logic              i_res_ready
);

    logic [1:0]        r_pc;
    logic [7:0]        r_pd;
    logic              r_err;
    logic [7:0]        r_tail [4];
    logic [2:0]        r_tcnt;
    logic [1:0]        r_sub;
    logic              r_ov;
    fupd_pkg::t_result r_res;

    logic [1:0]        w_n;
    logic [7:0]        w_b0;
    logic [7:0]        w_b1;
    logic [7:0]        w_b2;
    logic [1:0]        n_pc;
    logic [7:0]        n_pd;
    logic              n_err;
    logic [7:0]        dec_b;
    logic              hv;
    logic              pct;
    logic [7:0]        cur_byte;
    logic              stat_word;
    logic              pdf_match;
    logic              out_free;
    logic              step;
    logic              last_step;
    logic              emit;
    fupd_pkg::t_result word;

    assign hv    = fupd_pkg::is_hex(i_tok.ch);
    assign pct   = i_tok.ch == fupd_pkg::CH_PCT;
    assign dec_b = {fupd_pkg::hex_val(r_pd), fupd_pkg::hex_val(i_tok.ch)};

    // Each word from the queue expands into at most three result words.
    always_comb begin
        w_n   = 2'd0;
        w_b0  = fupd_pkg::CH_PCT;
        w_b1  = r_pd;
        w_b2  = i_tok.ch;
        n_pc  = r_pc;
        n_pd  = r_pd;
        n_err = r_err;
        if (i_tok.is_end) begin
            n_pc  = 2'd0;
            n_err = 1'b0;
            if (r_err) begin
                w_n = 2'd1;
            end else begin
                case (r_pc)
                    2'd1:    w_n = 2'd2;
                    2'd2:    w_n = 2'd3;
                    default: w_n = 2'd1;
                endcase
            end
        end else if (!r_err) begin
            case (r_pc)
                2'd2: begin
                    if (hv) begin
                        n_pc = 2'd0;
                        if (dec_b == 8'd0) begin
                            n_err = 1'b1;
                        end else begin
                            w_n  = 2'd1;
                            w_b0 = dec_b;
                        end
                    end else if (pct) begin
                        w_n  = 2'd2;
                        n_pc = 2'd1;
                    end else begin
                        w_n  = 2'd3;
                        n_pc = 2'd0;
                    end
                end
                2'd1: begin
                    if (hv) begin
                        n_pd = i_tok.ch;
                        n_pc = 2'd2;
                    end else if (pct) begin
                        w_n = 2'd1;
                    end else begin
                        w_n  = 2'd2;
                        w_b1 = i_tok.ch;
                        n_pc = 2'd0;
                    end
                end
                default: begin
                    if (pct) begin
                        n_pc = 2'd1;
                    end else begin
                        w_n  = 2'd1;
                        w_b0 = i_tok.ch;
                    end
                end
            endcase
        end
    end

    always_comb begin
        case (r_sub)
            2'd0:    cur_byte = w_b0;
            2'd1:    cur_byte = w_b1;
            default: cur_byte = w_b2;
        endcase
    end

    always_comb begin
        pdf_match = r_tcnt >= fupd_pkg::TAIL_FULL;
        for (int i = 0; i < 4; i++) begin
            if (fupd_pkg::to_lower(r_tail[i]) != fupd_pkg::pdf_char(2'(i))) begin
                pdf_match = 1'b0;
            end
        end
    end

    assign last_step = (w_n == 2'd0) || (r_sub == 2'(w_n - 2'd1));
    assign stat_word = i_tok.is_end && last_step;

    always_comb begin
        if (stat_word) begin
            word.out_char      = 8'd0;
            word.char_valid    = 1'b0;
            word.end_of_string = 1'b1;
            word.status        = r_err;
            word.pdf_suffix    = !r_err && pdf_match;
        end else begin
            word.out_char      = cur_byte;
            word.char_valid    = 1'b1;
            word.end_of_string = 1'b0;
            word.status        = 1'b0;
            word.pdf_suffix    = 1'b0;
        end
    end

    assign out_free    = !r_ov || i_res_ready;
    assign step        = i_tok_valid && ((w_n == 2'd0) || out_free);
    assign emit        = step && (w_n != 2'd0);
    assign o_tok_ready = step && last_step;
    assign o_res_valid = r_ov;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_res <= word;
        end
        if (emit && !stat_word) begin
            r_tail[0] <= r_tail[1];
            r_tail[1] <= r_tail[2];
            r_tail[2] <= r_tail[3];
            r_tail[3] <= cur_byte;
        end
        if (o_tok_ready) begin
            r_pd <= n_pd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= 2'd0;
            r_err  <= 1'b0;
            r_tcnt <= 3'd0;
            r_sub  <= 2'd0;
            r_ov   <= 1'b0;
        end else begin
            if (emit) begin
                r_ov <= 1'b1;
            end else if (i_res_ready) begin
                r_ov <= 1'b0;
            end
            if (o_tok_ready && i_tok.is_end) begin
                r_tcnt <= 3'd0;
            end else if (emit && !stat_word && r_tcnt != fupd_pkg::TAIL_FULL) begin
                r_tcnt <= r_tcnt + 3'd1;
            end
            if (step) begin
                if (last_step) begin
                    r_sub <= 2'd0;
                    r_pc  <= n_pc;
                    r_err <= n_err;
                end else begin
                    r_sub <= r_sub + 2'd1;
                end
            end
        end
    end

    `FUPD_ASSERT_IMPL(a_sub_in_list, i_tok_valid && w_n != 2'd0, r_sub < w_n, "step index beyond word list")
    `FUPD_ASSERT_IMPL(a_no_byte_after_error, emit && !stat_word, !r_err, "byte emitted after error")
    `FUPD_ASSERT_NEXT(a_end_clears, o_tok_ready && i_tok.is_end, !r_err && r_pc == 2'd0 && r_tcnt == 3'd0, "state not cleared after end")

endmodule

/* rtl/core/file_uri_percent_decoder_unit.sv */
`timescale 1ns / 1ps
// A plain character passes the front stage, the queue and the result register.
// Throughput: one word per cycle unless the output stalls; a word that expands
// into several result words (prefix flush, broken escape, end of string) emits them in turn.
// The front stage holds its input while it flushes a matched prefix part.
// Reset is synchronous and active low; it clears all control state at once.

module file_uri_percent_decoder_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_char,
    input  logic       i_has_char,
    input  logic       i_is_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_char,
    output logic       o_char_valid,
    output logic       o_end_of_string,
    output logic       o_status,
    output logic       o_pdf_suffix
);

    logic              front_valid;
    logic              front_ready;
    fupd_pkg::t_token  front_tok;
    logic              back_valid;
    logic              back_ready;
    fupd_pkg::t_token  back_tok;
    fupd_pkg::t_result res;

    fupd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_in_char   (i_in_char),
        .i_has_char  (i_has_char),
        .i_is_last   (i_is_last),
        .o_tok_valid (front_valid),
        .o_tok       (front_tok),
        .i_tok_ready (front_ready)
    );

    fupd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_data       (front_tok),
        .o_pop_valid  (back_valid),
        .i_pop_ready  (back_ready),
        .o_data       (back_tok)
    );

    fupd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (back_valid),
        .o_tok_ready (back_ready),
        .i_tok       (back_tok),
        .o_res_valid (o_valid),
        .o_res       (res),
        .i_res_ready (i_ready)
    );

    assign o_out_char      = res.out_char;
    assign o_char_valid    = res.char_valid;
    assign o_end_of_string = res.end_of_string;
    assign o_status        = res.status;
    assign o_pdf_suffix    = res.pdf_suffix;

endmodule

/* verif/tb_file_uri_percent_decoder_unit.sv */
`timescale 1ns / 1ps

module tb_file_uri_percent_decoder_unit;

    localparam logic [55:0] URI_HEAD       = "file://";
    localparam int          URI_HEAD_LEN   = 7;
    localparam logic [7:0]  PERCENT        = "%";
    localparam logic [31:0] PDF_TAIL       = ".pdf";
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          HOLD_OFF_LEN   = 80;
    localparam int          PRINT_CAP      = 50;

    typedef struct packed {
        logic [7:0] ch;
        logic       has;
        logic       last;
    } uri_word_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       end_of_string;
        logic       status;
        logic       pdf_suffix;
    } decoded_word_t;

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_valid         = 1'b0;
    logic [7:0] i_in_char       = 8'h00;
    logic       i_has_char      = 1'b0;
    logic       i_is_last       = 1'b0;
    logic       i_ready         = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_out_char;
    logic       o_char_valid;
    logic       o_end_of_string;
    logic       o_status;
    logic       o_pdf_suffix;

    uri_word_t     pending_words[$];
    decoded_word_t expected_decoded[$];
    logic [7:0]    draft[$];

    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int hold_requests   = 0;
    int holds_served    = 0;
    int hold_left       = 0;
    int words_queued    = 0;
    int counted_words   = 0;
    int words_accepted  = 0;
    int results_checked = 0;
    int strings_closed  = 0;
    int error_strings   = 0;
    int pdf_strings     = 0;
    int mismatch_count  = 0;
    int idle_cycles     = 0;
    logic in_fire       = 1'b0;

    logic [2:0]  head_matched;
    logic        head_settled;
    logic [1:0]  esc_held;
    logic [7:0]  esc_digit;
    logic        zero_hit;
    logic [31:0] last4;
    logic [2:0]  last4_count;

    file_uri_percent_decoder_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_in_char       (i_in_char),
        .i_has_char      (i_has_char),
        .i_is_last       (i_is_last),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_char      (o_out_char),
        .o_char_valid    (o_char_valid),
        .o_end_of_string (o_end_of_string),
        .o_status        (o_status),
        .o_pdf_suffix    (o_pdf_suffix)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] head_char(input int idx);
        return URI_HEAD[8 * (URI_HEAD_LEN - 1 - idx) +: 8];
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= "A" && c <= "Z") begin
            return c + 8'd32;
        end
        return c;
    endfunction

    function automatic int nibble_of(input logic [7:0] c);
        logic [7:0] l;
        l = fold_case(c);
        if (c >= "0" && c <= "9") begin
            return int'(c) - int'("0");
        end
        if (l >= "a" && l <= "f") begin
            return int'(l) - int'("a") + 10;
        end
        return -1;
    endfunction

    function automatic void clear_decoder();
        head_matched = '0;
        head_settled = 1'b0;
        esc_held     = '0;
        esc_digit    = '0;
        zero_hit     = 1'b0;
        last4        = '0;
        last4_count  = '0;
    endfunction

    function automatic void put_byte(input logic [7:0] b);
        decoded_word_t w;
        if (zero_hit) begin
            return;
        end
        w = '0;
        w.out_char   = b;
        w.char_valid = 1'b1;
        expected_decoded.push_back(w);
        last4 = {last4[23:0], b};
        if (last4_count < 3'd4) begin
            last4_count = last4_count + 3'd1;
        end
    endfunction

    function automatic void decode_byte(input logic [7:0] c);
        int hv;
        int hd;
        logic [7:0] b;
        if (zero_hit) begin
            return;
        end
        hv = nibble_of(c);
        if (esc_held == 2'd2) begin
            if (hv >= 0) begin
                hd = nibble_of(esc_digit);
                b = 8'(hd * 16 + hv);
                esc_held = 2'd0;
                if (b == 8'h00) begin
                    zero_hit = 1'b1;
                end else begin
                    put_byte(b);
                end
                return;
            end
            put_byte(PERCENT);
            put_byte(esc_digit);
            esc_held = 2'd0;
        end else if (esc_held == 2'd1) begin
            if (hv >= 0) begin
                esc_digit = c;
                esc_held = 2'd2;
                return;
            end
            put_byte(PERCENT);
            esc_held = 2'd0;
        end
        if (c == PERCENT) begin
            esc_held = 2'd1;
        end else begin
            put_byte(c);
        end
    endfunction

    function automatic void flush_head();
        int i;
        for (i = 0; i < int'(head_matched); i++) begin
            decode_byte(head_char(i));
        end
        head_matched = '0;
        head_settled = 1'b1;
    endfunction

    function automatic void decode_uri_word(input uri_word_t w);
        decoded_word_t fin;
        if (w.has) begin
            if (!head_settled) begin
                if (w.ch == head_char(int'(head_matched))) begin
                    head_matched = head_matched + 3'd1;
                    if (int'(head_matched) == URI_HEAD_LEN) begin
                        head_matched = '0;
                        head_settled = 1'b1;
                    end
                end else begin
                    flush_head();
                    decode_byte(w.ch);
                end
            end else begin
                decode_byte(w.ch);
            end
        end
        if (w.last) begin
            if (!head_settled) begin
                flush_head();
            end
            if (!zero_hit) begin
                if (esc_held == 2'd1) begin
                    put_byte(PERCENT);
                end else if (esc_held == 2'd2) begin
                    put_byte(PERCENT);
                    put_byte(esc_digit);
                end
            end
            fin = '0;
            fin.end_of_string = 1'b1;
            fin.status = zero_hit;
            if (!zero_hit && last4_count >= 3'd4) begin
                fin.pdf_suffix = {fold_case(last4[31:24]), fold_case(last4[23:16]),
                                  fold_case(last4[15:8]), fold_case(last4[7:0])} == PDF_TAIL;
            end
            expected_decoded.push_back(fin);
            clear_decoder();
        end
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    function automatic void queue_word(input logic [7:0] ch, input logic has,
                                       input logic last);
        uri_word_t w;
        w.ch = ch;
        w.has = has;
        w.last = last;
        pending_words.push_back(w);
        words_queued++;
        if (has || last) begin
            counted_words++;
        end
    endfunction

    function automatic void queue_text(input string s, input bit marker);
        int i;
        for (i = 0; i < s.len(); i++) begin
            queue_word(s[i], 1'b1, !marker && i == s.len() - 1);
        end
        if (marker) begin
            queue_word(8'($urandom_range(255)), 1'b0, 1'b1);
        end
    endfunction

    function automatic logic [7:0] hex_char(input int v);
        if (v < 10) begin
            return 8'(int'("0") + v);
        end
        return 8'(($urandom_range(1) ? int'("A") : int'("a")) + v - 10);
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(255));
        end while (nibble_of(c) >= 0);
        return c;
    endfunction

    function automatic logic [7:0] rand_case(input logic [7:0] c);
        return $urandom_range(1) ? c - 8'd32 : c;
    endfunction

    function automatic void add_token();
        int pick;
        pick = $urandom_range(99);
        if (pick < 35) begin
            draft.push_back(8'($urandom_range(126, 32)));
        end else if (pick < 55) begin
            draft.push_back(PERCENT);
            if ($urandom_range(99) < 4) begin
                draft.push_back("0");
                draft.push_back("0");
            end else begin
                draft.push_back(hex_char($urandom_range(15)));
                draft.push_back(hex_char($urandom_range(15)));
            end
        end else if (pick < 70) begin
            draft.push_back(PERCENT);
            if ($urandom_range(1)) begin
                draft.push_back(hex_char($urandom_range(15)));
            end
            draft.push_back($urandom_range(3) == 0 ? PERCENT : non_hex_char());
        end else if (pick < 90) begin
            draft.push_back(8'($urandom_range(255)));
        end else begin
            draft.push_back(PERCENT);
        end
    endfunction

    function automatic void queue_random_string();
        int pick;
        int i;
        int cut;
        int noise_at;
        bit marker;
        draft.delete();
        pick = $urandom_range(99);
        if (pick < 40) begin
            for (i = 0; i < URI_HEAD_LEN; i++) begin
                draft.push_back(head_char(i));
            end
        end else if (pick < 60) begin
            cut = $urandom_range(URI_HEAD_LEN - 1, 1);
            for (i = 0; i < cut; i++) begin
                draft.push_back(head_char(i));
            end
        end
        repeat ($urandom_range(6, 0)) begin
            add_token();
        end
        pick = $urandom_range(99);
        if (pick < 30) begin
            draft.push_back(".");
            draft.push_back(rand_case("p"));
            draft.push_back(rand_case("d"));
            draft.push_back(rand_case("f"));
        end else if (pick < 38) begin
            draft.push_back(PERCENT);
            draft.push_back("2");
            draft.push_back(rand_case("e"));
            draft.push_back("p");
            draft.push_back("d");
            draft.push_back("f");
        end else if (pick < 44) begin
            draft.push_back(".");
            draft.push_back("p");
            draft.push_back("d");
        end
        noise_at = ($urandom_range(99) < 15) ? $urandom_range(draft.size()) : -1;
        marker = (draft.size() == 0) || ($urandom_range(3) == 0);
        for (i = 0; i < draft.size(); i++) begin
            if (i == noise_at) begin
                queue_word(8'($urandom_range(255)), 1'b0, 1'b0);
            end
            queue_word(draft[i], 1'b1, !marker && i == draft.size() - 1);
        end
        if (noise_at == draft.size()) begin
            queue_word(8'($urandom_range(255)), 1'b0, 1'b0);
        end
        if (marker) begin
            queue_word(8'($urandom_range(255)), 1'b0, 1'b1);
        end
    endfunction

    function automatic void queue_random_words(input int n);
        int start;
        start = counted_words;
        while (counted_words - start < n) begin
            queue_random_string();
        end
    endfunction

    task automatic settle();
        do begin
            @(negedge i_clk);
        end while (words_accepted != words_queued || expected_decoded.size() != 0);
        repeat (8) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_fire) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_valid    <= 1'b1;
                i_in_char  <= pending_words[0].ch;
                i_has_char <= pending_words[0].has;
                i_is_last  <= pending_words[0].last;
                void'(pending_words.pop_front());
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (holds_served != hold_requests) begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_OFF_LEN;
            i_ready      <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= $urandom_range(99) >= recv_stall_pct;
        end
    end

    always @(posedge i_clk) begin : monitor
        uri_word_t     seen;
        decoded_word_t want;
        if (i_rst_n) begin
            in_fire <= i_valid && o_ready;
            if (i_valid && o_ready) begin
                seen.ch   = i_in_char;
                seen.has  = i_has_char;
                seen.last = i_is_last;
                decode_uri_word(seen);
                words_accepted++;
            end
            if (o_valid && i_ready) begin
                results_checked++;
                if (expected_decoded.size() == 0) begin
                    report_mismatch($sformatf("word with nothing expected: char %02h end %0b",
                                              o_out_char, o_end_of_string));
                end else begin
                    want = expected_decoded.pop_front();
                    if (o_out_char !== want.out_char) begin
                        report_mismatch($sformatf("out_char %02h, expected %02h",
                                                  o_out_char, want.out_char));
                    end
                    if (o_char_valid !== want.char_valid) begin
                        report_mismatch($sformatf("char_valid %0b, expected %0b",
                                                  o_char_valid, want.char_valid));
                    end
                    if (o_end_of_string !== want.end_of_string) begin
                        report_mismatch($sformatf("end_of_string %0b, expected %0b",
                                                  o_end_of_string, want.end_of_string));
                    end
                    if (o_status !== want.status) begin
                        report_mismatch($sformatf("status %0b, expected %0b",
                                                  o_status, want.status));
                    end
                    if (o_pdf_suffix !== want.pdf_suffix) begin
                        report_mismatch($sformatf("pdf_suffix %0b, expected %0b",
                                                  o_pdf_suffix, want.pdf_suffix));
                    end
                    if (want.end_of_string) begin
                        strings_closed++;
                        error_strings += want.status;
                        pdf_strings   += want.pdf_suffix;
                    end
                end
            end
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles <= 0;
            end else if (expected_decoded.size() != 0 || pending_words.size() != 0
                         || i_valid) begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no word moved for %0d cycles.", WATCHDOG_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        clear_decoder();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        queue_text("file://%4a.PdF", 0);
        queue_word(8'h00, 1'b1, 1'b0);
        queue_word(8'hFF, 1'b1, 1'b1);
        queue_word(8'hA5, 1'b0, 1'b0);
        queue_text("fi", 1);
        queue_text("%4%", 1);
        queue_text("%00x", 0);
        queue_random_words(105);
        settle();

        send_idle_pct = 79;
        queue_random_words(105);
        settle();

        send_idle_pct  = 0;
        recv_stall_pct = 79;
        queue_random_words(105);
        settle();

        send_idle_pct  = 14;
        recv_stall_pct = 14;
        queue_random_words(105);
        settle();

        // The output is held off while words keep coming, so the input must stall.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests++;
        queue_random_words(40);
        settle();

        $display("Run covered %0d input words (%0d strings) and %0d result words.",
                 words_accepted, strings_closed, results_checked);
        $display("Strings with decoded zero byte: %0d; with pdf suffix: %0d.",
                 error_strings, pdf_strings);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/fupd_pkg.sv
rtl/core/fupd_front.sv
rtl/core/fupd_queue.sv
rtl/core/fupd_back.sv
rtl/core/file_uri_percent_decoder_unit.sv
verif/tb_file_uri_percent_decoder_unit.sv
